### design/lfu_pkg.sv
// Package for the LFU key/value table: item types, state encoding and constants.
// Used by lfu_cache_table and lfu_checker; depends on nothing.
package lfu_pkg;

   localparam logic       CMD_GET        = 1'b0;
   localparam logic       CMD_PUT        = 1'b1;
   localparam int         CAP_WIDTH      = 5;
   localparam logic [4:0] CAPACITY_RESET = 5'd16;
   localparam logic [31:0] MISS_VALUE    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

### design/lfu_cache_table.sv
// Fully associative key/value table with LFU replacement, oldest first among equal counts.
// Depends on lfu_pkg for item types, state encoding and constants.
// An accepted item goes through the scan, drain, update and result states, in that order.
// The single-port scan reads one entry at a time; no new item is taken until the result is loaded.
// Reset (synchronous, active high): all entries invalid, occupancy zero, capacity 16.
// Key, value and count storage is not cleared; an entry is read only once marked valid.
module lfu_cache_table #(
   parameter int ENTRIES     = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lfu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lfu_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [lfu_pkg::CAP_WIDTH-1:0] csr_wr_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int OW = $clog2(ENTRIES + 1);

   lfu_pkg::state_type state_ff, state_in;

   logic [lfu_pkg::CAP_WIDTH-1:0] capacity_ff;
   logic [OW-1:0]                 occ_ff, occ_in;
   logic [OW-1:0]                 limit;

   lfu_pkg::req_type req_ff;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [AW-1:0]      age_ff [ENTRIES];
   logic [AW-1:0]      age_in [ENTRIES];

   logic [31:0]            key_mem   [ENTRIES];
   logic [31:0]            value_mem [ENTRIES];
   logic [COUNT_WIDTH-1:0] count_mem [ENTRIES];
   logic [31:0]            key_rd_ff;
   logic [31:0]            value_rd_ff;
   logic [COUNT_WIDTH-1:0] count_rd_ff;

   logic          rd_en;
   logic [AW-1:0] idx_ff, idx_in;
   logic          chk_ff;
   logic [AW-1:0] chk_idx_ff;

   logic                   hit_ff;
   logic [AW-1:0]          hit_slot_ff;
   logic [31:0]            hit_value_ff;
   logic [COUNT_WIDTH-1:0] hit_count_ff;
   logic [AW-1:0]          hit_age_ff;
   logic                   vic_found_ff;
   logic [AW-1:0]          vic_slot_ff;
   logic [COUNT_WIDTH-1:0] vic_count_ff;
   logic [AW-1:0]          vic_age_ff;
   logic [31:0]            vic_key_ff;
   logic                   free_found_ff;
   logic [AW-1:0]          free_slot_ff;

   logic          chk_valid;
   logic [AW-1:0] chk_age;
   logic          key_match;
   logic          vic_better;

   logic                   do_touch, do_insert, do_evict, ins_ok, upd;
   logic [AW-1:0]          slot;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [31:0]            wr_value;
   logic [COUNT_WIDTH-1:0] wr_count;

   lfu_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lfu_pkg::rsp_type rsp_ff;
   logic             rsp_load;

   // capacity and limit
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lfu_pkg::CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (capacity_ff == '0) begin
         limit = OW'(1);
      end else if (32'(capacity_ff) > 32'(ENTRIES)) begin
         limit = OW'(ENTRIES);
      end else begin
         limit = OW'(capacity_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lfu_pkg::ST_SCAN;
            end
         end
         lfu_pkg::ST_SCAN: begin
            if (idx_ff == AW'(ENTRIES - 1)) begin
               state_in = lfu_pkg::ST_DRAIN;
            end
         end
         lfu_pkg::ST_DRAIN:  state_in = lfu_pkg::ST_UPDATE;
         lfu_pkg::ST_UPDATE: state_in = lfu_pkg::ST_RESP;
         lfu_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         default: state_in = lfu_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      upd       = 1'b0;
      rsp_load  = 1'b0;
      idx_in    = idx_ff;
      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            idx_in    = '0;
         end
         lfu_pkg::ST_SCAN: begin
            rd_en  = 1'b1;
            idx_in = idx_ff + AW'(1);
         end
         lfu_pkg::ST_DRAIN: begin
         end
         lfu_pkg::ST_UPDATE: begin
            upd = 1'b1;
         end
         lfu_pkg::ST_RESP: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_ff   <= rd_en;
      end
      idx_ff     <= idx_in;
      chk_idx_ff <= idx_ff;
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_rd_ff   <= key_mem[idx_ff];
         value_rd_ff <= value_mem[idx_ff];
         count_rd_ff <= count_mem[idx_ff];
      end
      if (wr_en) begin
         key_mem[wr_addr]   <= req_ff.key;
         value_mem[wr_addr] <= wr_value;
         count_mem[wr_addr] <= wr_count;
      end
   end

   // scan compare
   assign chk_valid  = valid_ff[chk_idx_ff];
   assign chk_age    = age_ff[chk_idx_ff];
   assign key_match  = chk_valid && (key_rd_ff == req_ff.key);
   assign vic_better = !vic_found_ff || (count_rd_ff < vic_count_ff) ||
                       ((count_rd_ff == vic_count_ff) && (chk_age > vic_age_ff));

   always_ff @(posedge clock) begin
      if (state_ff == lfu_pkg::ST_IDLE) begin
         hit_ff        <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (chk_ff) begin
         if (key_match) begin
            hit_ff       <= 1'b1;
            hit_slot_ff  <= chk_idx_ff;
            hit_value_ff <= value_rd_ff;
            hit_count_ff <= count_rd_ff;
            hit_age_ff   <= chk_age;
         end
         if (chk_valid && vic_better) begin
            vic_found_ff <= 1'b1;
            vic_slot_ff  <= chk_idx_ff;
            vic_count_ff <= count_rd_ff;
            vic_age_ff   <= chk_age;
            vic_key_ff   <= key_rd_ff;
         end
         if (!chk_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= chk_idx_ff;
         end
      end
   end

   // update decision
   assign do_touch  = hit_ff;
   assign do_insert = (req_ff.cmd == lfu_pkg::CMD_PUT) && !hit_ff;
   assign do_evict  = do_insert && (occ_ff >= limit) && vic_found_ff;
   assign ins_ok    = do_evict || free_found_ff;
   assign slot      = do_evict ? vic_slot_ff : free_slot_ff;

   assign wr_en    = upd && (do_touch || (do_insert && ins_ok));
   assign wr_addr  = do_touch ? hit_slot_ff : slot;
   assign wr_value = (req_ff.cmd == lfu_pkg::CMD_PUT) ? req_ff.value : hit_value_ff;
   always_comb begin
      if (!do_touch) begin
         wr_count = COUNT_WIDTH'(1);
      end else if (hit_count_ff == '1) begin
         wr_count = hit_count_ff;
      end else begin
         wr_count = hit_count_ff + COUNT_WIDTH'(1);
      end
   end

   // recency ages, one cell per entry
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (upd && do_touch) begin
            if (AW'(i) == hit_slot_ff) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < hit_age_ff)) begin
               age_in[i] = age_ff[i] + AW'(1);
            end
         end else if (upd && do_insert && ins_ok) begin
            if (AW'(i) == slot) begin
               age_in[i]   = '0;
               valid_in[i] = 1'b1;
            end else if (valid_ff[i] && !(do_evict && (age_ff[i] > vic_age_ff))) begin
               age_in[i] = age_ff[i] + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         age_ff[i] <= age_in[i];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (upd && do_insert && ins_ok && !do_evict) begin
         occ_in = occ_ff + OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // result
   always_comb begin
      res_in.hit         = hit_ff;
      res_in.evicted     = do_evict;
      res_in.evicted_key = do_evict ? vic_key_ff : '0;
      if (req_ff.cmd == lfu_pkg::CMD_PUT) begin
         res_in.read_value = '0;
      end else if (hit_ff) begin
         res_in.read_value = hit_value_ff;
      end else begin
         res_in.read_value = lfu_pkg::MISS_VALUE;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (upd) begin
         res_ff <= res_in;
      end
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/lfu_checker.sv
// Port-level checks for lfu_cache_table, attached by the bind below.
// Depends on lfu_pkg for the item types.
module lfu_props (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lfu_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous item in progress");

   a_evict_put_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> !rsp_data.hit && rsp_data.read_value == 0)
      else $error("eviction reported on non-inserting item");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.evicted |-> rsp_data.evicted_key == 0)
      else $error("evicted key set without eviction");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lfu_cache_table lfu_props u_lfu_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
